FILE: rtl/lznt1_pkg.sv
// ----------------------------------------------------------------------------
// lznt1_pkg
// Shared types and constants for the LZNT1 unit decoder.
// ----------------------------------------------------------------------------
package lznt1_pkg;

    localparam int MAX_OUTPUT = 65536;
    localparam int CNT_W      = $clog2(MAX_OUTPUT + 1);
    localparam int LIMIT_W    = 17;
    localparam int LIM_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = 12;
    localparam int POS_W      = 13;
    localparam logic [POS_W-1:0] POS_SAT = 13'd4097;
    localparam int QUEUE_DEPTH = 2;

    // Operation codes of an input word.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Status codes of a result word.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_REFUSED = 2'd1;
    localparam logic [1:0] STAT_BAD     = 2'd2;
    localparam logic [1:0] STAT_STOP    = 2'd3;

    // Register indexes of the configuration port.
    localparam logic REG_OUT_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        PH_HDR_LO  = 3'd0,
        PH_HDR_HI  = 3'd1,
        PH_STORED  = 3'd2,
        PH_FLAG    = 3'd3,
        PH_ITEM    = 3'd4,
        PH_CODE_HI = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        RUN_ACTIVE  = 2'd0,
        RUN_STOP    = 2'd1,
        RUN_BAD     = 2'd2,
        RUN_SRC_END = 2'd3
    } run_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // Queue head handed from the front to the back.
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

FILE: rtl/lznt1_if.sv
// ----------------------------------------------------------------------------
// lznt1_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface lznt1_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output op, output data_byte, output last_byte,
                    input ready);
    modport sink (input valid, input op, input data_byte, input last_byte,
                  output ready);
endinterface

interface lznt1_out_if;
    logic       valid;
    logic       ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    logic [1:0] status;
    logic       unit_done;
    modport source (output valid, output out_valid, output out_byte,
                    output copy_pending, output status, output unit_done,
                    input ready);
    modport sink (input valid, input out_valid, input out_byte,
                  input copy_pending, input status, input unit_done,
                  output ready);
endinterface

FILE: rtl/lznt1_ram.sv
// ----------------------------------------------------------------------------
// lznt1_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lznt1_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/lznt1_front.sv
// ----------------------------------------------------------------------------
// lznt1_front
// Accepts input words into a two-entry queue ahead of the decoder.
// ----------------------------------------------------------------------------
module lznt1_front (
    input  logic               clk,
    input  logic               rst_n,
    lznt1_in_if.sink           in_ch,
    output lznt1_pkg::head_t   head,
    input  logic               pop
);
    import lznt1_pkg::*;

    item_t      slot_reg [QUEUE_DEPTH];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;

    assign in_ch.ready = (count_reg != 2'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign do_pop      = pop && (count_reg != 2'd0);

    // Pointer and occupancy update.
    always_comb
    begin
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{op: in_ch.op, data_byte: in_ch.data_byte,
                                      last_byte: in_ch.last_byte};
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

endmodule

FILE: rtl/lznt1_back.sv
// ----------------------------------------------------------------------------
// lznt1_back
// Decodes one queued word per cycle unless output stalls; holds the result.
// ----------------------------------------------------------------------------
module lznt1_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lznt1_pkg::head_t              head,
    output logic                          pop,
    input  logic [lznt1_pkg::LIMIT_W-1:0] out_limit,
    lznt1_out_if.source                   out_ch
);
    import lznt1_pkg::*;

    phase_t            phase_reg, phase_next;
    run_t              run_reg, run_next;
    logic [7:0]        hdr_lo_reg, hdr_lo_next;
    logic [12:0]       chunk_left_reg, chunk_left_next;
    logic              compressed_reg, compressed_next;
    logic [7:0]        flags_reg, flags_next;
    logic [3:0]        flag_cnt_reg, flag_cnt_next;
    logic [7:0]        code_lo_reg, code_lo_next;
    logic [12:0]       copy_left_reg, copy_left_next;
    logic [12:0]       dist_reg, dist_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              o_v_reg;
    logic              o_valid_reg, o_valid_next;
    logic [7:0]        o_byte_reg, o_byte_next;
    logic              o_pend_reg, o_pend_next;
    logic [1:0]        o_stat_reg, o_stat_next;
    logic              o_done_reg, o_done_next;

    logic              we;
    logic [HIST_AW-1:0] waddr, raddr;
    logic [7:0]        wdata, ram_q, hist_byte;
    logic              byp_hit_reg;
    logic [7:0]        byp_data_reg;

    logic [LIM_W-1:0]  lim;
    logic              fire;
    logic              op;
    logic [7:0]        b;
    logic              last;
    logic [15:0]       code;
    logic [4:0]        lbits;
    logic [15:0]       lmask;
    logic [12:0]       mlen, mdist;
    logic              reached;

    assign lim  = (LIM_W'(out_limit) > LIM_W'(MAX_OUTPUT)) ? LIM_W'(MAX_OUTPUT)
                                                            : LIM_W'(out_limit);
    assign fire = head.valid && (!o_v_reg || out_ch.ready);
    assign pop  = fire;
    assign op   = head.item.op;
    assign b    = head.item.data_byte;
    assign last = head.item.last_byte;

    // Split of a back-reference code by the position within the chunk.
    always_comb
    begin
        lbits = 5'd12;
        for (int d = 5; d <= 12; d++)
        begin
            if ((13'd1 << (d - 1)) < pos_reg)
            begin
                lbits = 5'(16 - d);
            end
        end
        code  = {b, code_lo_reg};
        lmask = (16'd1 << lbits) - 16'd1;
        mlen  = 13'((code & lmask) + 16'd3);
        mdist = 13'((code >> lbits) + 16'd1);
    end

    // History byte for the next drain, with a bypass for a same-cycle write.
    assign hist_byte = byp_hit_reg ? byp_data_reg : ram_q;

    // One decode step.
    always_comb
    begin
        phase_next      = phase_reg;
        run_next        = run_reg;
        hdr_lo_next     = hdr_lo_reg;
        chunk_left_next = chunk_left_reg;
        compressed_next = compressed_reg;
        flags_next      = flags_reg;
        flag_cnt_next   = flag_cnt_reg;
        code_lo_next    = code_lo_reg;
        copy_left_next  = copy_left_reg;
        dist_next       = dist_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        o_valid_next    = 1'b0;
        o_byte_next     = 8'd0;
        o_stat_next     = STAT_OK;
        o_done_next     = 1'b0;
        we              = 1'b0;
        wdata           = b;
        waddr           = cnt_reg[HIST_AW-1:0];
        reached         = 1'b0;

        if (fire)
        begin
            if (op == OP_DRAIN)
            begin
                if (copy_left_reg != 13'd0)
                begin
                    if (LIM_W'(cnt_reg) < lim)
                    begin
                        we             = 1'b1;
                        wdata          = hist_byte;
                        cnt_next       = cnt_reg + 1'b1;
                        pos_next       = (pos_reg < POS_SAT) ? pos_reg + 1'b1 : pos_reg;
                        copy_left_next = copy_left_reg - 1'b1;
                        o_valid_next   = 1'b1;
                        o_byte_next    = hist_byte;
                    end
                    if (LIM_W'(cnt_next) >= lim)
                    begin
                        copy_left_next = 13'd0;
                        o_stat_next    = STAT_STOP;
                        if (run_reg == RUN_SRC_END)
                        begin
                            o_done_next = 1'b1;
                        end
                        else
                        begin
                            run_next = RUN_STOP;
                        end
                    end
                    else if (copy_left_next == 13'd0 && run_reg == RUN_SRC_END)
                    begin
                        o_done_next = 1'b1;
                    end
                end
                else
                begin
                    o_stat_next = (run_reg == RUN_STOP) ? STAT_STOP :
                                  (run_reg == RUN_BAD) ? STAT_BAD : STAT_OK;
                end
            end
            else if (copy_left_reg != 13'd0)
            begin
                o_stat_next = STAT_REFUSED;
            end
            else
            begin
                if (run_reg == RUN_ACTIVE && LIM_W'(cnt_reg) >= lim)
                begin
                    run_next = RUN_STOP;
                end
                else if (run_reg == RUN_ACTIVE)
                begin
                    case (phase_reg)
                        PH_HDR_LO:
                        begin
                            hdr_lo_next = b;
                            phase_next  = PH_HDR_HI;
                        end
                        PH_HDR_HI:
                        begin
                            if (b == 8'd0 && hdr_lo_reg == 8'd0)
                            begin
                                run_next = RUN_STOP;
                            end
                            else
                            begin
                                chunk_left_next = {1'b0, b[3:0], hdr_lo_reg} + 13'd1;
                                compressed_next = b[7];
                                pos_next        = '0;
                                phase_next      = b[7] ? PH_FLAG : PH_STORED;
                            end
                        end
                        PH_STORED:
                        begin
                            we              = 1'b1;
                            cnt_next        = cnt_reg + 1'b1;
                            pos_next        = (pos_reg < POS_SAT) ? pos_reg + 1'b1 : pos_reg;
                            o_valid_next    = 1'b1;
                            o_byte_next     = b;
                            chunk_left_next = chunk_left_reg - 1'b1;
                            if (chunk_left_next == 13'd0)
                            begin
                                phase_next = PH_HDR_LO;
                            end
                        end
                        PH_FLAG:
                        begin
                            flags_next      = b;
                            flag_cnt_next   = 4'd8;
                            chunk_left_next = chunk_left_reg - 1'b1;
                            phase_next      = (chunk_left_next == 13'd0) ? PH_HDR_LO : PH_ITEM;
                        end
                        PH_ITEM:
                        begin
                            chunk_left_next = chunk_left_reg - 1'b1;
                            if (flags_reg[0])
                            begin
                                code_lo_next = b;
                                if (chunk_left_next == 13'd0 || last)
                                begin
                                    run_next = RUN_BAD;
                                end
                                else
                                begin
                                    phase_next = PH_CODE_HI;
                                end
                            end
                            else
                            begin
                                we           = 1'b1;
                                cnt_next     = cnt_reg + 1'b1;
                                pos_next     = (pos_reg < POS_SAT) ? pos_reg + 1'b1 : pos_reg;
                                o_valid_next = 1'b1;
                                o_byte_next  = b;
                                flags_next   = flags_reg >> 1;
                                flag_cnt_next = (flag_cnt_reg != 4'd0) ? flag_cnt_reg - 1'b1
                                                                       : flag_cnt_reg;
                                phase_next   = (chunk_left_next == 13'd0) ? PH_HDR_LO :
                                               (flag_cnt_next == 4'd0) ? PH_FLAG : PH_ITEM;
                            end
                        end
                        PH_CODE_HI:
                        begin
                            chunk_left_next = chunk_left_reg - 1'b1;
                            if (mdist > pos_reg)
                            begin
                                run_next = RUN_BAD;
                            end
                            else
                            begin
                                copy_left_next = mlen;
                                dist_next      = mdist;
                                flags_next     = flags_reg >> 1;
                                flag_cnt_next  = (flag_cnt_reg != 4'd0) ? flag_cnt_reg - 1'b1
                                                                        : flag_cnt_reg;
                                phase_next     = (chunk_left_next == 13'd0) ? PH_HDR_LO :
                                                 (flag_cnt_next == 4'd0) ? PH_FLAG : PH_ITEM;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HDR_LO;
                        end
                    endcase
                    reached = (LIM_W'(cnt_next) >= lim);
                    if (run_next == RUN_ACTIVE && reached)
                    begin
                        run_next       = RUN_STOP;
                        copy_left_next = 13'd0;
                    end
                end
                o_stat_next = (run_next == RUN_STOP) ? STAT_STOP :
                              (run_next == RUN_BAD) ? STAT_BAD : STAT_OK;
                if (last)
                begin
                    if (copy_left_next != 13'd0 && run_next == RUN_ACTIVE)
                    begin
                        run_next = RUN_SRC_END;
                    end
                    else
                    begin
                        o_done_next = 1'b1;
                    end
                end
            end

            o_pend_next = (copy_left_next != 13'd0) && !o_done_next;

            // A finished unit clears all parse state.
            if (o_done_next)
            begin
                phase_next      = PH_HDR_LO;
                run_next        = RUN_ACTIVE;
                hdr_lo_next     = 8'd0;
                chunk_left_next = 13'd0;
                compressed_next = 1'b0;
                flags_next      = 8'd0;
                flag_cnt_next   = 4'd0;
                code_lo_next    = 8'd0;
                copy_left_next  = 13'd0;
                dist_next       = 13'd0;
                pos_next        = '0;
                cnt_next        = '0;
            end
        end
        else
        begin
            o_pend_next = o_pend_reg;
        end

        raddr = cnt_next[HIST_AW-1:0] - dist_next[HIST_AW-1:0];
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR_LO;
            run_reg        <= RUN_ACTIVE;
            hdr_lo_reg     <= 8'd0;
            chunk_left_reg <= 13'd0;
            compressed_reg <= 1'b0;
            flags_reg      <= 8'd0;
            flag_cnt_reg   <= 4'd0;
            code_lo_reg    <= 8'd0;
            copy_left_reg  <= 13'd0;
            dist_reg       <= 13'd0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            o_v_reg        <= 1'b0;
            byp_hit_reg    <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            run_reg        <= run_next;
            hdr_lo_reg     <= hdr_lo_next;
            chunk_left_reg <= chunk_left_next;
            compressed_reg <= compressed_next;
            flags_reg      <= flags_next;
            flag_cnt_reg   <= flag_cnt_next;
            code_lo_reg    <= code_lo_next;
            copy_left_reg  <= copy_left_next;
            dist_reg       <= dist_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            byp_hit_reg    <= we && (waddr == raddr);
            if (fire)
            begin
                o_v_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                o_v_reg <= 1'b0;
            end
        end
    end

    // Result word and bypass data.
    always_ff @(posedge clk)
    begin
        byp_data_reg <= wdata;
        if (fire)
        begin
            o_valid_reg <= o_valid_next;
            o_byte_reg  <= o_byte_next;
            o_pend_reg  <= o_pend_next;
            o_stat_reg  <= o_stat_next;
            o_done_reg  <= o_done_next;
        end
    end

    lznt1_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign out_ch.valid        = o_v_reg;
    assign out_ch.out_valid    = o_valid_reg;
    assign out_ch.out_byte     = o_byte_reg;
    assign out_ch.copy_pending = o_pend_reg;
    assign out_ch.status       = o_stat_reg;
    assign out_ch.unit_done    = o_done_reg;

endmodule

FILE: rtl/lznt1_decompressor_top.sv
// ----------------------------------------------------------------------------
// lznt1_decompressor_top
// LZNT1 unit decoder: one compressed byte or drain tick in, one result out.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Word
//  in_ch    | in        | op, data_byte, last_byte
//  out_ch   | out       | out_valid, out_byte, copy_pending, status, unit_done
//  APB      | in/out    | out_limit at byte address 0
//
// One word per cycle sustained unless the output stalls; an accepted word is
// registered in a queue slot, then its result in the result register. The
// decode step with one history RAM read and write sets that rate.
// Reset clears the queue and all parse state; the history RAM is not cleared.
// Input stalls only when the two-entry queue is full behind a stalled output.
// ----------------------------------------------------------------------------
module lznt1_decompressor_top (
    input  logic        clk,
    input  logic        rst_n,
    lznt1_in_if.sink    in_ch,
    lznt1_out_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lznt1_pkg::*;

    logic [LIMIT_W-1:0] out_limit_reg;
    head_t              head;
    logic               pop;

    assign pready = 1'b1;

    // Configuration register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_limit_reg <= LIMIT_W'(65536);
        end
        else if (psel && penable && pwrite && paddr[2] == REG_OUT_LIMIT)
        begin
            out_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // Register read-back.
    assign prdata = (paddr[2] == REG_OUT_LIMIT) ? {{(32-LIMIT_W){1'b0}}, out_limit_reg}
                                                : 32'd0;

    lznt1_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .head  (head),
        .pop   (pop)
    );

    lznt1_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_limit (out_limit_reg),
        .out_ch    (out_ch)
    );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LZNT1 unit decoder. Compressed units are built
// on the fly, fed in with drain ticks as the decoder asks for them, and every
// result word is compared with a cycle-free software decoder kept in step.
// ----------------------------------------------------------------------------
module testbench;
    import lznt1_pkg::*;

    typedef struct {
        logic       ov;
        logic [7:0] ob;
        logic       cp;
        logic [1:0] st;
        logic       ud;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lznt1_in_if  in_ch ();
    lznt1_out_if out_ch ();

    lznt1_decompressor_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Decoder shadow state.
    logic [16:0] limit_reg;
    phase_t      phase;
    run_t        run_st;
    logic [7:0]  hdr_lo;
    int unsigned chunk_left;
    logic [7:0]  flags;
    int unsigned flag_cnt;
    logic [7:0]  code_lo;
    int unsigned copy_left;
    int unsigned copy_dist;
    int unsigned chunk_pos;
    int unsigned out_cnt;
    logic [7:0]  history [HIST_DEPTH];

    result_t     expected_q [$];
    bit [8:0]    stream_q [$];
    int          errors;
    bit          no_idle;
    int          refuse_pct;
    int          words_sent;

    always #5 clk = ~clk;

    // Clear per-unit parse state; history and limit survive.
    function automatic void clear_unit();
        phase = PH_HDR_LO;
        run_st = RUN_ACTIVE;
        hdr_lo = 0;
        chunk_left = 0;
        flags = 0;
        flag_cnt = 0;
        code_lo = 0;
        copy_left = 0;
        copy_dist = 0;
        chunk_pos = 0;
        out_cnt = 0;
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        history[out_cnt & 12'hFFF] = b;
        out_cnt++;
        if (chunk_pos < POS_SAT) chunk_pos++;
    endfunction

    function automatic logic [1:0] run_status();
        if (run_st == RUN_STOP) return STAT_STOP;
        if (run_st == RUN_BAD) return STAT_BAD;
        return STAT_OK;
    endfunction

    function automatic void advance_item();
        flags = flags >> 1;
        if (flag_cnt > 0) flag_cnt--;
        if (chunk_left == 0) phase = PH_HDR_LO;
        else if (flag_cnt == 0) phase = PH_FLAG;
        else phase = PH_ITEM;
    endfunction

    // Work out the result word of one accepted input word.
    function automatic result_t decode_word(logic op, logic [7:0] b, logic last);
        result_t     r;
        int unsigned lim;
        int unsigned code;
        int unsigned dbits;
        int unsigned lbits;
        int unsigned len;
        int unsigned disp;
        r = '{1'b0, 8'd0, 1'b0, STAT_OK, 1'b0};
        lim = (limit_reg > MAX_OUTPUT) ? MAX_OUTPUT : limit_reg;
        if (op == OP_DRAIN)
        begin
            if (copy_left > 0)
            begin
                if (out_cnt < lim)
                begin
                    r.ob = history[(out_cnt - copy_dist) & 12'hFFF];
                    emit_byte(r.ob);
                    copy_left--;
                    r.ov = 1;
                end
                if (out_cnt >= lim)
                begin
                    copy_left = 0;
                    r.st = STAT_STOP;
                    if (run_st == RUN_SRC_END) r.ud = 1;
                    else run_st = RUN_STOP;
                end
                else if (copy_left == 0 && run_st == RUN_SRC_END)
                begin
                    r.ud = 1;
                end
            end
            else
            begin
                r.st = run_status();
            end
        end
        else if (copy_left > 0)
        begin
            r.st = STAT_REFUSED;
        end
        else
        begin
            if (run_st == RUN_ACTIVE && out_cnt >= lim)
            begin
                run_st = RUN_STOP;
            end
            else if (run_st == RUN_ACTIVE)
            begin
                case (phase)
                    PH_HDR_LO:
                    begin
                        hdr_lo = b;
                        phase = PH_HDR_HI;
                    end
                    PH_HDR_HI:
                    begin
                        if (hdr_lo == 0 && b == 0)
                        begin
                            run_st = RUN_STOP;
                        end
                        else
                        begin
                            chunk_left = {b[3:0], hdr_lo} + 1;
                            chunk_pos = 0;
                            phase = b[7] ? PH_FLAG : PH_STORED;
                        end
                    end
                    PH_STORED:
                    begin
                        emit_byte(b);
                        r.ov = 1;
                        r.ob = b;
                        chunk_left--;
                        if (chunk_left == 0) phase = PH_HDR_LO;
                    end
                    PH_FLAG:
                    begin
                        flags = b;
                        flag_cnt = 8;
                        chunk_left--;
                        phase = (chunk_left == 0) ? PH_HDR_LO : PH_ITEM;
                    end
                    PH_ITEM:
                    begin
                        chunk_left--;
                        if (flags[0])
                        begin
                            code_lo = b;
                            if (chunk_left == 0 || last) run_st = RUN_BAD;
                            else phase = PH_CODE_HI;
                        end
                        else
                        begin
                            emit_byte(b);
                            r.ov = 1;
                            r.ob = b;
                            advance_item();
                        end
                    end
                    default:
                    begin
                        code = {b, code_lo};
                        chunk_left--;
                        dbits = 12;
                        while (dbits > 4 && !((1 << (dbits - 1)) < chunk_pos)) dbits--;
                        lbits = 16 - dbits;
                        len = (code & ((1 << lbits) - 1)) + 3;
                        disp = (code >> lbits) + 1;
                        if (disp > chunk_pos)
                        begin
                            run_st = RUN_BAD;
                        end
                        else
                        begin
                            copy_left = len;
                            copy_dist = disp;
                            advance_item();
                        end
                    end
                endcase
                if (run_st == RUN_ACTIVE && out_cnt >= lim)
                begin
                    run_st = RUN_STOP;
                    copy_left = 0;
                end
            end
            r.st = run_status();
            if (last)
            begin
                if (copy_left > 0 && run_st == RUN_ACTIVE) run_st = RUN_SRC_END;
                else r.ud = 1;
            end
        end
        r.cp = (copy_left != 0);
        if (r.ud)
        begin
            clear_unit();
            r.cp = 0;
        end
        return r;
    endfunction

    // Offer one word, wait for it to be taken, and log its expected result.
    task automatic send_word(logic op, logic [7:0] b, logic last);
        bit taken;
        // Random gaps leave the input idle before about a fifth of the words.
        if (!no_idle && $urandom_range(0, 99) < 20)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
        end
        expected_q.insert(expected_q.size(), decode_word(op, b, last));
        words_sent++;
    endtask

    // Drop the input valid after the last word of a burst.
    task automatic stop_input();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Feed the queued stream, paying out matches with drain ticks.
    task automatic send_stream();
        bit [8:0] w;
        while (stream_q.size() > 0)
        begin
            w = stream_q.pop_front();
            while (copy_left > 0)
            begin
                if ($urandom_range(0, 99) < refuse_pct)
                    send_word(OP_BYTE, w[7:0], w[8]);
                send_word(OP_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 99) < 3)
                send_word(OP_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_word(OP_BYTE, w[7:0], w[8]);
        end
        while (copy_left > 0)
            send_word(OP_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        stop_input();
    endtask

    task automatic push_bytes(input bit [7:0] bytes [], input bit mark_last);
        foreach (bytes[i])
            stream_q.insert(stream_q.size(), {mark_last && i == bytes.size() - 1, bytes[i]});
    endtask

    // Append one chunk of about the given body size to the stream.
    task automatic add_chunk(int target, bit comp, int long_pct);
        bit [7:0]    body [$];
        bit [7:0]    fl;
        int          fidx;
        int unsigned pos;
        int unsigned dbits;
        int unsigned lb;
        int unsigned maxd;
        int unsigned maxl;
        int unsigned disp;
        int unsigned lenf;
        int unsigned code;
        logic [15:0] hdr;
        pos = 0;
        if (!comp)
        begin
            repeat (target) body.insert(body.size(), 8'($urandom_range(0, 255)));
        end
        else
        begin
            while (body.size() < target)
            begin
                fl = 8'($urandom_range(0, 255));
                fidx = body.size();
                body.insert(body.size(), 8'd0);
                for (int k = 0; k < 8 && body.size() < target; k++)
                begin
                    if (fl[k] && pos > 0)
                    begin
                        dbits = 12;
                        while (dbits > 4 && !((1 << (dbits - 1)) < pos)) dbits--;
                        lb = 16 - dbits;
                        maxd = (pos < (1 << dbits)) ? pos : (1 << dbits);
                        disp = $urandom_range(1, maxd);
                        // Long matches stay within 258 drain ticks.
                        maxl = (1 << lb) - 1;
                        if (maxl > 255) maxl = 255;
                        if ($urandom_range(0, 99) < long_pct)
                            lenf = $urandom_range(0, maxl);
                        else
                            lenf = $urandom_range(0, (maxl < 7) ? maxl : 7);
                        code = ((disp - 1) << lb) | lenf;
                        body.insert(body.size(), code[7:0]);
                        body.insert(body.size(), code[15:8]);
                        pos += lenf + 3;
                        if (pos > POS_SAT) pos = POS_SAT;
                    end
                    else
                    begin
                        fl[k] = 1'b0;
                        body.insert(body.size(), 8'($urandom_range(0, 255)));
                        if (pos < POS_SAT) pos++;
                    end
                end
                body[fidx] = fl;
            end
        end
        hdr = {comp, 3'($urandom_range(0, 7)), 12'(body.size() - 1)};
        stream_q.insert(stream_q.size(), {1'b0, hdr[7:0]});
        stream_q.insert(stream_q.size(), {1'b0, hdr[15:8]});
        foreach (body[i]) stream_q.insert(stream_q.size(), {1'b0, body[i]});
    endtask

    // Build one random unit, mostly well formed, sometimes damaged.
    task automatic build_unit();
        int n;
        int cut;
        n = $urandom_range(1, 3);
        repeat (n) add_chunk($urandom_range(2, 40), $urandom_range(0, 99) < 75, 3);
        if ($urandom_range(0, 99) < 70)
        begin
            stream_q.insert(stream_q.size(), 9'h000);
            stream_q.insert(stream_q.size(), 9'h000);
        end
        if ($urandom_range(0, 99) < 10)
        begin
            cut = $urandom_range(0, stream_q.size() - 1);
            stream_q[cut][7:0] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < 5 && stream_q.size() > 2)
        begin
            cut = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > cut) void'(stream_q.pop_back());
        end
        stream_q[stream_q.size() - 1][8] = 1'b1;
    endtask

    // Wait until the decoder has gone quiet, then write out_limit.
    task automatic write_limit(logic [16:0] value);
        wait (expected_q.size() == 0);
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_OUT_LIMIT) << 2;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_reg = value;
    endtask

    // Stored chunks with extreme bytes.
    task automatic test_stored();
        push_bytes('{8'h03, 8'h70, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h00, 8'h00}, 1);
        send_stream();
        add_chunk(48, 0, 0);
        stream_q[stream_q.size() - 1][8] = 1'b1;
        send_stream();
    endtask

    // Literals, a back-reference, a refused byte and an idle drain tick.
    task automatic test_compressed();
        send_word(OP_DRAIN, 8'hFF, 1'b0);
        refuse_pct = 100;
        push_bytes('{8'h05, 8'h80, 8'h08, 8'h41, 8'h42, 8'h43, 8'h02, 8'h20,
                     8'h00, 8'h00}, 1);
        send_stream();
        refuse_pct = 5;
        // The unit ends on a reference, so its last word is a drain tick.
        push_bytes('{8'h05, 8'h80, 8'h08, 8'h41, 8'h42, 8'h43, 8'h02, 8'h20}, 1);
        send_stream();
    endtask

    // Malformed references and a header cut short.
    task automatic test_malformed();
        // Displacement reaching before the chunk start.
        push_bytes('{8'h03, 8'h80, 8'h02, 8'h58, 8'h00, 8'h10, 8'h77, 8'h88}, 1);
        send_stream();
        // Reference whose first byte is the last of the unit.
        push_bytes('{8'h04, 8'h80, 8'h02, 8'h58, 8'h00}, 1);
        send_stream();
        // Reference whose first byte ends the chunk.
        push_bytes('{8'h01, 8'h80, 8'h01, 8'h00, 8'h00, 8'h99}, 1);
        send_stream();
        push_bytes('{8'h12}, 1);
        send_stream();
    endtask

    // Random units under several output limits.
    task automatic test_limits();
        logic [16:0] limits [5];
        limits = '{17'd0, 17'd1, 17'd20, 17'h1FFFF, 17'($urandom_range(0, 131071))};
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            build_unit();
            send_stream();
        end
        write_limit(17'd65536);
    endtask

    // One longer compressed chunk with long matches across several offset splits.
    task automatic test_long_chunk();
        add_chunk(60, 1, 20);
        stream_q[stream_q.size() - 1][8] = 1'b1;
        send_stream();
    endtask

    // Random units up to the word budget, with one stretch free of idling.
    task automatic test_random();
        int start;
        start = words_sent;
        while (words_sent < 850 || words_sent - start < 200)
        begin
            no_idle = (words_sent - start) >= 50 && (words_sent - start) < 150;
            build_unit();
            send_stream();
        end
        no_idle = 0;
    endtask

    // Result port: random stalls with one stretch held open.
    always @(posedge clk)
    begin
        if (!rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 35);
    end

    // Check each result word at the falling edge before it is taken.
    always @(negedge clk)
    begin
        result_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result word, actual %b %h %b %h %b", $time,
                         out_ch.out_valid, out_ch.out_byte, out_ch.copy_pending,
                         out_ch.status, out_ch.unit_done);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_ch.out_valid !== e.ov || out_ch.out_byte !== e.ob ||
                    out_ch.copy_pending !== e.cp || out_ch.status !== e.st ||
                    out_ch.unit_done !== e.ud)
                begin
                    $display("%0t: mismatch, expected %b %h %b %h %b, actual %b %h %b %h %b",
                             $time, e.ov, e.ob, e.cp, e.st, e.ud,
                             out_ch.out_valid, out_ch.out_byte, out_ch.copy_pending,
                             out_ch.status, out_ch.unit_done);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_ch.valid = 0;
        in_ch.op = OP_BYTE;
        in_ch.data_byte = 0;
        in_ch.last_byte = 0;
        out_ch.ready = 0;
        errors = 0;
        no_idle = 0;
        refuse_pct = 5;
        words_sent = 0;
        limit_reg = 17'd65536;
        clear_unit();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stored();
        test_compressed();
        test_malformed();
        test_long_chunk();
        test_limits();
        test_random();
        wait (expected_q.size() == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lznt1_pkg.sv
rtl/lznt1_if.sv
rtl/lznt1_ram.sv
rtl/lznt1_front.sv
rtl/lznt1_back.sv
rtl/lznt1_decompressor_top.sv
tb/testbench.sv
